[src/smhpq_pkg.sv]
`timescale 1ns / 1ps

package smhpq_pkg;

   localparam int KEY_BITS             = 32;
   localparam int ORDER_BITS           = 32;
   localparam int STATUS_BITS          = 2;
   localparam int OCC_BITS             = 5;
   localparam int TREE_LEVELS_DEFAULT  = 5;
   localparam int PAYLOAD_BITS_DEFAULT = 64;

   // request operations
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   // the part of an entry that decides service order
   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic [ORDER_BITS-1:0]      order;
   } rank_type;

endpackage

[src/smhpq_rank.sv]
`timescale 1ns / 1ps

// shared ranking comparator: a_first is high when a must be served before b
module smhpq_rank (
   input  smhpq_pkg::rank_type a,
   input  smhpq_pkg::rank_type b,
   output logic                a_first
);

   logic key_greater;
   logic key_equal;
   logic order_earlier;

   always_comb begin
      key_greater   = a.key > b.key;
      key_equal     = a.key == b.key;
      order_earlier = a.order < b.order;
      a_first       = key_greater || (key_equal && order_earlier);
   end

endmodule

[src/stable_max_heap_priority_queue.sv]
`timescale 1ns / 1ps

// Stable max-heap priority queue holding up to 2^TREE_LEVELS - 1 entries in one
// memory with one write port and two registered read ports. Each request is an
// enqueue (key, payload) or a dequeue; every request gives exactly one response
// carrying a status, the dequeued entry (zero unless a dequeue succeeded) and the
// occupancy afterwards (low five bits). The largest key is served first and equal
// keys leave in arrival order; the arrival stamp restarts at zero whenever the
// queue runs empty. The block takes one item at a time and stalls its request
// side until that item's response is loaded into the output register. An enqueue
// reads the parent and, while the new entry ranks first, moves the parent down,
// level by level, until the entry settles or reaches the root; it climbs at most
// TREE_LEVELS - 1 levels. A dequeue reads the root and the last entry, then per
// level reads both children, picks the better child and compares it with the
// moved entry until that entry settles or reaches a leaf; taking the last entry
// skips the sift-down. Rejected and empty requests go straight to the reply step.
// Each level costs a memory read plus one pass of the shared ranking comparator.
// A finished response sits in an output register, so a new request can be taken
// once that register is loaded, while the previous response may still be waiting
// to be picked up; a stalled response holds back only the reply step of the next item.
module stable_max_heap_priority_queue #(
   parameter int TREE_LEVELS  = smhpq_pkg::TREE_LEVELS_DEFAULT,
   parameter int PAYLOAD_BITS = smhpq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic signed [smhpq_pkg::KEY_BITS-1:0]  req_key,
   input  logic [PAYLOAD_BITS-1:0]                req_payload,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [smhpq_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic signed [smhpq_pkg::KEY_BITS-1:0]  rsp_out_key,
   output logic [PAYLOAD_BITS-1:0]                rsp_out_payload,
   output logic [smhpq_pkg::ORDER_BITS-1:0]       rsp_out_order,
   output logic [smhpq_pkg::OCC_BITS-1:0]         rsp_occupancy
);

   localparam int DEPTH  = (1 << TREE_LEVELS) - 1;
   localparam int WORD_W = smhpq_pkg::KEY_BITS + smhpq_pkg::ORDER_BITS + PAYLOAD_BITS;
   localparam int KEY_HI = WORD_W - 1;
   localparam int ORD_HI = PAYLOAD_BITS + smhpq_pkg::ORDER_BITS - 1;
   localparam logic [TREE_LEVELS-1:0] FULL_COUNT = {TREE_LEVELS{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SU_ISSUE,   // sift-up: fetch parent or settle at the root
      ST_SU_MOVE,    // sift-up: compare with parent, move parent down or settle
      ST_DQ_FETCH,   // dequeue: fetch root and last entry
      ST_DQ_LOAD,    // dequeue: capture root, hold last entry
      ST_SD_ISSUE,   // sift-down: fetch both children or settle at a leaf
      ST_SD_PICK,    // sift-down: pick the better child
      ST_SD_MOVE,    // sift-down: compare child with held entry
      ST_REPLY
   } state_type;

   // heap storage, undefined until written
   logic [WORD_W-1:0] heap_mem [0:DEPTH-1];

   // control
   state_type                             state_ff, state_in;
   logic [TREE_LEVELS-1:0]                count_ff, count_in;
   logic [smhpq_pkg::ORDER_BITS-1:0]      arrival_ff, arrival_in;
   logic [TREE_LEVELS-1:0]                pos_ff, pos_in;
   logic [TREE_LEVELS-1:0]                best_idx_ff, best_idx_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [WORD_W-1:0]                     cur_ff, cur_in;
   logic [WORD_W-1:0]                     best_ff, best_in;
   logic [WORD_W-1:0]                     rd_a_ff, rd_b_ff;
   logic [smhpq_pkg::STATUS_BITS-1:0]     res_status_ff, res_status_in;
   logic [WORD_W-1:0]                     res_word_ff, res_word_in;
   logic [smhpq_pkg::STATUS_BITS-1:0]     rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]                     rsp_word_ff, rsp_word_in;
   logic [smhpq_pkg::OCC_BITS-1:0]        rsp_occ_ff, rsp_occ_in;

   // memory ports
   logic [TREE_LEVELS-1:0]                rd_a_addr, rd_b_addr, wr_addr;
   logic [WORD_W-1:0]                     wr_data;
   logic                                  wr_en;

   // index arithmetic
   logic [TREE_LEVELS-1:0]                parent_idx;
   logic [TREE_LEVELS:0]                  child_lo, child_hi, count_wide;
   logic                                  has_child, has_two;

   // shared comparator
   smhpq_pkg::rank_type                   cmp_a, cmp_b;
   logic                                  cmp_a_first;
   logic                                  req_accept;

   function automatic smhpq_pkg::rank_type rank_of(input logic [WORD_W-1:0] w);
      smhpq_pkg::rank_type r;
      r.key   = w[KEY_HI -: smhpq_pkg::KEY_BITS];
      r.order = w[ORD_HI -: smhpq_pkg::ORDER_BITS];
      return r;
   endfunction

   smhpq_rank u_rank (
      .a       (cmp_a),
      .b       (cmp_b),
      .a_first (cmp_a_first)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // tree navigation, children need one extra bit near the bottom level
   assign parent_idx = (pos_ff - 1'b1) >> 1;
   assign child_lo   = {pos_ff, 1'b1};
   assign child_hi   = child_lo + 1'b1;
   assign count_wide = {1'b0, count_ff};
   assign has_child  = child_lo < count_wide;
   assign has_two    = child_hi < count_wide;

   // comparator operand selection per sequencer step
   always_comb begin
      case (state_ff)
         ST_SU_MOVE: begin
            cmp_a = rank_of(cur_ff);
            cmp_b = rank_of(rd_a_ff);
         end
         ST_SD_PICK: begin
            cmp_a = rank_of(rd_b_ff);
            cmp_b = rank_of(rd_a_ff);
         end
         default: begin
            cmp_a = rank_of(best_ff);
            cmp_b = rank_of(cur_ff);
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      arrival_in    = arrival_ff;
      pos_in        = pos_ff;
      best_idx_in   = best_idx_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      res_status_in = res_status_ff;
      res_word_in   = res_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rd_a_addr     = parent_idx;
      rd_b_addr     = count_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_word_in   = '0;
               res_status_in = smhpq_pkg::STATUS_DONE;
               if (req_op == smhpq_pkg::OP_ENQUEUE) begin
                  if (count_ff == FULL_COUNT) begin
                     res_status_in = smhpq_pkg::STATUS_FULL;
                     state_in      = ST_REPLY;
                  end else begin
                     cur_in     = {req_key, arrival_ff, req_payload};
                     pos_in     = count_ff;
                     count_in   = count_ff + 1'b1;
                     arrival_in = arrival_ff + 1'b1;
                     state_in   = ST_SU_ISSUE;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = smhpq_pkg::STATUS_EMPTY;
                     arrival_in    = '0;
                     state_in      = ST_REPLY;
                  end else begin
                     count_in = count_ff - 1'b1;
                     state_in = ST_DQ_FETCH;
                  end
               end
            end
         end
         ST_SU_ISSUE: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_REPLY;
            end else begin
               state_in = ST_SU_MOVE;
            end
         end
         ST_SU_MOVE: begin
            wr_en = 1'b1;
            if (cmp_a_first) begin
               wr_data  = rd_a_ff;
               pos_in   = parent_idx;
               state_in = ST_SU_ISSUE;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_DQ_FETCH: begin
            // count already reduced, so it addresses the last entry
            rd_a_addr = '0;
            state_in  = ST_DQ_LOAD;
         end
         ST_DQ_LOAD: begin
            res_word_in = rd_a_ff;
            cur_in      = rd_b_ff;
            pos_in      = '0;
            if (count_ff == '0) begin
               arrival_in = '0;
               state_in   = ST_REPLY;
            end else begin
               state_in = ST_SD_ISSUE;
            end
         end
         ST_SD_ISSUE: begin
            rd_a_addr = child_lo[TREE_LEVELS-1:0];
            rd_b_addr = child_hi[TREE_LEVELS-1:0];
            if (has_child) begin
               state_in = ST_SD_PICK;
            end else begin
               wr_en    = 1'b1;
               state_in = ST_REPLY;
            end
         end
         ST_SD_PICK: begin
            // read addresses stay on the children while this step runs
            rd_a_addr = child_lo[TREE_LEVELS-1:0];
            rd_b_addr = child_hi[TREE_LEVELS-1:0];
            if (has_two && cmp_a_first) begin
               best_in     = rd_b_ff;
               best_idx_in = child_hi[TREE_LEVELS-1:0];
            end else begin
               best_in     = rd_a_ff;
               best_idx_in = child_lo[TREE_LEVELS-1:0];
            end
            state_in = ST_SD_MOVE;
         end
         ST_SD_MOVE: begin
            wr_en = 1'b1;
            if (cmp_a_first) begin
               wr_data  = best_ff;
               pos_in   = best_idx_ff;
               state_in = ST_SD_ISSUE;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_word_in   = res_word_ff;
               rsp_occ_in    = smhpq_pkg::OCC_BITS'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         arrival_ff   <= '0;
         pos_ff       <= '0;
         best_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         arrival_ff   <= arrival_in;
         pos_ff       <= pos_in;
         best_idx_ff  <= best_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      res_status_ff <= res_status_in;
      res_word_ff   <= res_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // heap memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_word_ff[KEY_HI -: smhpq_pkg::KEY_BITS];
   assign rsp_out_order   = rsp_word_ff[ORD_HI -: smhpq_pkg::ORDER_BITS];
   assign rsp_out_payload = rsp_word_ff[PAYLOAD_BITS-1:0];
   assign rsp_occupancy   = rsp_occ_ff;

endmodule
